// File: design/iab_pkg.sv
// ----------------------------------------------------------------------------
// iab_pkg
// Shared types, constants and the first-octant arctangent table for the
// vector angle pipeline.
// ----------------------------------------------------------------------------
package iab_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int QBITS           = 6;
  localparam int ANGLE_WIDTH     = 8;
  localparam int QMAX            = 32;

  localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN = 8'd64;
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN    = 8'd128;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic swap;
    logic zero;
  } flags_t;

  // atan(i/32) in brads
  function automatic logic [ANGLE_WIDTH-1:0] octant_atan(input logic [QBITS-1:0] q);
    logic [ANGLE_WIDTH-1:0] a;
    case (q)
      6'd0:  a = 8'd0;
      6'd1:  a = 8'd1;
      6'd2:  a = 8'd3;
      6'd3:  a = 8'd4;
      6'd4:  a = 8'd5;
      6'd5:  a = 8'd6;
      6'd6:  a = 8'd8;
      6'd7:  a = 8'd9;
      6'd8:  a = 8'd10;
      6'd9:  a = 8'd11;
      6'd10: a = 8'd12;
      6'd11: a = 8'd13;
      6'd12: a = 8'd15;
      6'd13: a = 8'd16;
      6'd14: a = 8'd17;
      6'd15: a = 8'd18;
      6'd16: a = 8'd19;
      6'd17: a = 8'd20;
      6'd18: a = 8'd21;
      6'd19: a = 8'd22;
      6'd20: a = 8'd23;
      6'd21: a = 8'd24;
      6'd22: a = 8'd25;
      6'd23: a = 8'd25;
      6'd24: a = 8'd26;
      6'd25: a = 8'd27;
      6'd26: a = 8'd28;
      6'd27: a = 8'd29;
      6'd28: a = 8'd29;
      6'd29: a = 8'd30;
      6'd30: a = 8'd31;
      6'd31: a = 8'd31;
      default: a = 8'd32;
    endcase
    return a;
  endfunction

endpackage

// File: design/iab_front.sv
// ----------------------------------------------------------------------------
// iab_front
// Input cell: forms both magnitudes, picks the octant and loads the divider
// chain with the smaller magnitude and twice the larger one.
// ----------------------------------------------------------------------------
module iab_front #(
  parameter int COORD_WIDTH = iab_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] y_coord,
  input  logic [COORD_WIDTH-1:0] x_coord,
  output logic                   valid,
  input  logic                   ready_next,
  output logic [COORD_WIDTH:0]   rem,
  output logic [COORD_WIDTH:0]   dvs,
  output iab_pkg::flags_t        flags
);
  import iab_pkg::*;

  logic                   yneg, xneg;
  logic [COORD_WIDTH-1:0] ay, ax, small_mag, large_mag;
  logic                   swap, ready;

  assign yneg = y_coord[COORD_WIDTH-1];
  assign xneg = x_coord[COORD_WIDTH-1];
  assign ay   = yneg ? COORD_WIDTH'(~y_coord + COORD_WIDTH'(1)) : y_coord;
  assign ax   = xneg ? COORD_WIDTH'(~x_coord + COORD_WIDTH'(1)) : x_coord;
  assign swap = ax < ay;
  assign small_mag = swap ? ax : ay;
  assign large_mag = swap ? ay : ax;

  assign ready    = !valid || ready_next;
  assign in_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      rem        <= {1'b0, small_mag};
      dvs        <= {large_mag, 1'b0};
      flags.xneg <= xneg;
      flags.yneg <= yneg;
      flags.swap <= swap;
      flags.zero <= (ax == '0) && (ay == '0);
    end
  end

endmodule

// File: design/iab_div_cell.sv
// ----------------------------------------------------------------------------
// iab_div_cell
// One restoring division step: doubles the remainder, compares it with the
// divisor and shifts one quotient bit in.
// ----------------------------------------------------------------------------
module iab_div_cell #(
  parameter int COORD_WIDTH = iab_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_prev,
  output logic                       ready,
  input  logic [COORD_WIDTH:0]       rem_prev,
  input  logic [COORD_WIDTH:0]       dvs_prev,
  input  logic [iab_pkg::QBITS-1:0]  q_prev,
  input  iab_pkg::flags_t            flags_prev,
  output logic                       valid,
  input  logic                       ready_next,
  output logic [COORD_WIDTH:0]       rem,
  output logic [COORD_WIDTH:0]       dvs,
  output logic [iab_pkg::QBITS-1:0]  q,
  output iab_pkg::flags_t            flags
);
  import iab_pkg::*;

  logic [COORD_WIDTH+1:0] trial, dext, diff;
  logic                   qbit;

  assign trial = {rem_prev, 1'b0};
  assign dext  = {1'b0, dvs_prev};
  assign qbit  = trial >= dext;
  assign diff  = qbit ? (trial - dext) : trial;

  assign ready = !valid || ready_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_prev) begin
      rem   <= diff[COORD_WIDTH:0];
      dvs   <= dvs_prev;
      q     <= {q_prev[QBITS-2:0], qbit};
      flags <= flags_prev;
    end
  end

endmodule

// File: design/iab_back.sv
// ----------------------------------------------------------------------------
// iab_back
// Output cell: table lookup, octant and quadrant mirror, result register.
// ----------------------------------------------------------------------------
module iab_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid_prev,
  output logic                            ready,
  input  logic [iab_pkg::QBITS-1:0]       q_prev,
  input  iab_pkg::flags_t                 flags_prev,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iab_pkg::ANGLE_WIDTH-1:0] angle
);
  import iab_pkg::*;

  logic [ANGLE_WIDTH-1:0] oct, base, ang;

  assign oct  = octant_atan(q_prev);
  assign base = flags_prev.swap ? (QUARTER_TURN - oct) : oct;

  always_comb begin
    if (flags_prev.zero) begin
      ang = '0;
    end else if (!flags_prev.xneg) begin
      ang = flags_prev.yneg ? ANGLE_WIDTH'(0 - base) : base;
    end else begin
      ang = flags_prev.yneg ? (HALF_TURN + base) : (HALF_TURN - base);
    end
  end

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= valid_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid_prev) begin
      angle <= ang;
    end
  end

endmodule

// File: design/integer_atan2_brads.sv
// ----------------------------------------------------------------------------
// integer_atan2_brads
// Angle of a signed (x, y) vector in brads, 256 to a full turn, through a
// chain of restoring division cells and an arctangent table.
// ----------------------------------------------------------------------------
//  channel | signals                          | dir
//  --------+----------------------------------+-----
//  input   | in_valid, in_stall, y_coord, x_coord | in
//  output  | out_valid, out_stall, angle      | out
//
//  one beat per cycle while out_stall is low; a beat passes through the input
//  cell, six division cells (one quotient bit each) and the output cell
//  each cell holds one beat and moves it on whenever the next cell frees up
//  rst clears the valid flags of all cells; payload is not reset
//  out_stall holds the result register and backs up through the chain
// ----------------------------------------------------------------------------
module integer_atan2_brads #(
  parameter int COORD_WIDTH = iab_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_WIDTH-1:0]          y_coord,
  input  logic [COORD_WIDTH-1:0]          x_coord,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iab_pkg::ANGLE_WIDTH-1:0] angle
);
  import iab_pkg::*;

  localparam int DEPTH   = QBITS + 2;
  localparam int OCC_W   = $clog2(DEPTH + 1);

  logic                   valid_c [QBITS+1];
  logic                   ready_c [1:QBITS];
  logic [COORD_WIDTH:0]   rem_c   [QBITS+1];
  logic [COORD_WIDTH:0]   dvs_c   [QBITS+1];
  logic [QBITS-1:0]       q_c     [QBITS+1];
  flags_t                 flags_c [QBITS+1];
  logic                   back_ready;
  logic [OCC_W-1:0]       occ, occ_next;
  logic                   in_beat, out_beat;

  assign q_c[0] = '0;

  iab_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .y_coord    (y_coord),
    .x_coord    (x_coord),
    .valid      (valid_c[0]),
    .ready_next (ready_c[1]),
    .rem        (rem_c[0]),
    .dvs        (dvs_c[0]),
    .flags      (flags_c[0])
  );

  for (genvar i = 1; i <= QBITS; i++) begin : g_cell
    logic ready_after;
    if (i == QBITS) begin : g_last
      assign ready_after = back_ready;
    end else begin : g_mid
      assign ready_after = ready_c[i+1];
    end

    iab_div_cell #(.COORD_WIDTH(COORD_WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .valid_prev (valid_c[i-1]),
      .ready      (ready_c[i]),
      .rem_prev   (rem_c[i-1]),
      .dvs_prev   (dvs_c[i-1]),
      .q_prev     (q_c[i-1]),
      .flags_prev (flags_c[i-1]),
      .valid      (valid_c[i]),
      .ready_next (ready_after),
      .rem        (rem_c[i]),
      .dvs        (dvs_c[i]),
      .q          (q_c[i]),
      .flags      (flags_c[i])
    );
  end

  iab_back u_back (
    .clk        (clk),
    .rst        (rst),
    .valid_prev (valid_c[QBITS]),
    .ready      (back_ready),
    .q_prev     (q_c[QBITS]),
    .flags_prev (flags_c[QBITS]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .angle      (angle)
  );

  // beats in flight
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  always_comb begin
    occ_next = occ;
    if (in_beat && !out_beat) begin
      occ_next = occ + OCC_W'(1);
    end else if (!in_beat && out_beat) begin
      occ_next = occ - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(DEPTH))
    else $error("more beats in flight than cells");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    occ == '0 |-> !out_valid)
    else $error("result shown with no beat in flight");

  a_quotient_range: assert property (@(posedge clk) disable iff (rst)
    valid_c[QBITS] && !flags_c[QBITS].zero |-> q_c[QBITS] <= QBITS'(QMAX))
    else $error("quotient beyond table");

  a_full_chain_stalls: assert property (@(posedge clk) disable iff (rst)
    occ == OCC_W'(DEPTH) && out_stall |-> in_stall)
    else $error("input taken with every cell full and output stalled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vector angle pipeline. Coordinate pairs go in
// through the valid/stall channel with random gaps, including directed corner
// vectors. Each accepted pair is turned into an expected brad angle by a local
// predictor, and every output beat is matched in order against those angles
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

  import iab_pkg::*;

  localparam int CW              = COORD_WIDTH_DEF;
  localparam int AW              = ANGLE_WIDTH;
  localparam int MAX_MAG         = 1 << (CW - 1);
  localparam int RANDOM_VECTORS  = 950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int LATENCY         = 8;
  localparam int NUM_DIRECTED    = 24;

  localparam logic [AW-1:0] OCT_ATAN [0:32] = '{
    8'd0,  8'd1,  8'd3,  8'd4,  8'd5,  8'd6,  8'd8,  8'd9,  8'd10, 8'd11, 8'd12,
    8'd13, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
    8'd25, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30, 8'd31, 8'd31, 8'd32
  };

  localparam int DIR_Y [NUM_DIRECTED] = '{
    0, 0, 32767, 0, -32768, -32768, 32767, -32768, 32767, -32767, 0, 1,
    0, -1, 1, -1, 1, -1, 100, 3200, -5, 7, -7, 1023
  };
  localparam int DIR_X [NUM_DIRECTED] = '{
    0, 32767, 0, -32768, 0, -32768, 32767, 32767, -32768, -32768, 1, 0,
    -1, 0, 1, -1, -1, 1, 3200, 100, 7, -5, -5, 1024
  };

  typedef struct {
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    logic [AW-1:0] angle;
  } angle_entry_t;

  class angle_scoreboard;
    angle_entry_t pending_angles[$];
    int           mismatches;

    function new();
      mismatches = 0;
    endfunction

    function logic [AW-1:0] predict_angle(logic [CW-1:0] y, logic [CW-1:0] x);
      logic [CW:0]   ay;
      logic [CW:0]   ax;
      logic [CW:0]   lo;
      logic [CW:0]   hi;
      logic [CW+5:0] q;
      logic [AW-1:0] oct;
      logic [AW-1:0] ang;
      ay = y[CW-1] ? {1'b0, ~y} + 1'b1 : {1'b0, y};
      ax = x[CW-1] ? {1'b0, ~x} + 1'b1 : {1'b0, x};
      if (ax == 0 && ay == 0) return '0;
      lo = (ax >= ay) ? ay : ax;
      hi = (ax >= ay) ? ax : ay;
      q  = {lo, 5'b0} / hi;
      if (q > QMAX) q = (CW+6)'(QMAX);
      oct = (ax >= ay) ? OCT_ATAN[q[5:0]] : QUARTER_TURN - OCT_ATAN[q[5:0]];
      if (!x[CW-1]) ang = y[CW-1] ? -oct : oct;
      else          ang = y[CW-1] ? HALF_TURN + oct : HALF_TURN - oct;
      return ang;
    endfunction

    function void flag_error(string msg);
      if (mismatches < 10) $display("%0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    function void note_vector(logic [CW-1:0] y, logic [CW-1:0] x);
      angle_entry_t e;
      e.y     = y;
      e.x     = x;
      e.angle = predict_angle(y, x);
      pending_angles.push_back(e);
    endfunction

    function void check_angle(logic [AW-1:0] got);
      angle_entry_t e;
      if (pending_angles.size() == 0) begin
        flag_error($sformatf("angle %0d arrived with no vector outstanding", got));
        return;
      end
      e = pending_angles.pop_front();
      if (got !== e.angle)
        flag_error($sformatf("angle mismatch y=%0d x=%0d: expected %0d got %0d",
                             $signed(e.y), $signed(e.x), e.angle, got));
    endfunction

    function int pending();
      return pending_angles.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [CW-1:0] y_coord;
  logic [CW-1:0] x_coord;
  logic          out_valid;
  logic          out_stall;
  logic [AW-1:0] angle;

  angle_scoreboard sb = new();
  bit              hold_off_req = 1'b0;
  int              burst_left   = 0;
  int              idle_cycles  = 0;

  integer_atan2_brads #(
    .COORD_WIDTH(CW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .y_coord  (y_coord),
    .x_coord  (x_coord),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle    (angle)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CW-1:0] signed_coord(int mag, bit neg);
    if (mag < 0) mag = 0;
    if (mag > MAX_MAG) mag = MAX_MAG;
    if (neg) return CW'(-mag);
    if (mag > MAX_MAG - 1) mag = MAX_MAG - 1;
    return CW'(mag);
  endfunction

  function automatic void make_vector(output logic [CW-1:0] y, output logic [CW-1:0] x);
    int r;
    int a;
    int b;
    int k;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      y = CW'($urandom);
      x = CW'($urandom);
    end else if (r < 55) begin
      y = signed_coord($urandom_range(0, 64), $urandom_range(0, 1));
      x = signed_coord($urandom_range(0, 64), $urandom_range(0, 1));
    end else if (r < 70) begin
      // near the octant diagonal
      a = $urandom_range(1, MAX_MAG);
      b = a + int'($urandom_range(0, 8)) - 4;
      y = signed_coord(a, $urandom_range(0, 1));
      x = signed_coord(b, $urandom_range(0, 1));
    end else if (r < 80) begin
      a = $urandom_range(0, MAX_MAG);
      if ($urandom_range(0, 1)) begin
        y = signed_coord(a, $urandom_range(0, 1));
        x = '0;
      end else begin
        y = '0;
        x = signed_coord(a, $urandom_range(0, 1));
      end
    end else if (r < 90) begin
      case ($urandom_range(0, 5))
        0: y = signed_coord(MAX_MAG, 1'b1);
        1: y = signed_coord(MAX_MAG - 1, 1'b1);
        2: y = signed_coord(1, 1'b1);
        3: y = '0;
        4: y = signed_coord(1, 1'b0);
        default: y = signed_coord(MAX_MAG - 1, 1'b0);
      endcase
      case ($urandom_range(0, 5))
        0: x = signed_coord(MAX_MAG, 1'b1);
        1: x = signed_coord(MAX_MAG - 1, 1'b1);
        2: x = signed_coord(1, 1'b1);
        3: x = '0;
        4: x = signed_coord(1, 1'b0);
        default: x = signed_coord(MAX_MAG - 1, 1'b0);
      endcase
    end else begin
      // ratio near a quotient step boundary
      a = $urandom_range(1, MAX_MAG);
      k = $urandom_range(0, QMAX);
      b = int'((longint'(a) * k) / QMAX) + int'($urandom_range(0, 2)) - 1;
      if (b > a) b = a;
      if ($urandom_range(0, 1)) begin
        y = signed_coord(b, $urandom_range(0, 1));
        x = signed_coord(a, $urandom_range(0, 1));
      end else begin
        y = signed_coord(a, $urandom_range(0, 1));
        x = signed_coord(b, $urandom_range(0, 1));
      end
    end
  endfunction

  task automatic send_vector(input logic [CW-1:0] y, input logic [CW-1:0] x, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    y_coord  <= y;
    x_coord  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_vector(y_coord, x_coord);
      if (out_valid && !out_stall) sb.check_angle(angle);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    int len;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    logic [CW-1:0] y;
    logic [CW-1:0] x;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    y_coord  <= '0;
    x_coord  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      y = CW'(DIR_Y[i]);
      x = CW'(DIR_X[i]);
      send_vector(y, x, next_gap());
    end

    for (int i = 0; i < RANDOM_VECTORS; i++) begin
      if (i == 100) hold_off_req = 1'b1;
      if (i == 500) drain_results();
      make_vector(y, x);
      send_vector(y, x, (i >= 100 && i < 160) ? 0 : next_gap());
    end

    drain_results();
    repeat (LATENCY + 12) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
design/iab_pkg.sv
design/iab_front.sv
design/iab_div_cell.sv
design/iab_back.sv
design/integer_atan2_brads.sv
tb/tb_top.sv
